@@ src/wsfp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 64;
  localparam int unsigned KeyW  = 32;

  localparam logic [ByteW-1:0] FinMask    = 8'h80;
  localparam logic [ByteW-1:0] OpcodeMask = 8'h0F;
  localparam logic [ByteW-1:0] LenMask    = 8'h7F;
  localparam logic [6:0]       Len16Code  = 7'd126;
  localparam logic [6:0]       Len64Code  = 7'd127;

  localparam logic [3:0] Len16Bytes = 4'd2;
  localparam logic [3:0] Len64Bytes = 4'd8;
  localparam logic [2:0] KeyLastIdx = 3'd3;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic             fin_flag;
    logic [3:0]       opcode;
    logic             masked_flag;
    logic [LenW-1:0]  payload_length;
    logic [ByteW-1:0] payload_byte;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

@@ src/wsfp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfp_if
// Valid/ready channels: raw frame bytes in, parse results out.
// ----------------------------------------------------------------------------
interface wsfp_byte_if;
  import wsfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsfp_res_if;
  import wsfp_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic             fin_flag;
  logic [3:0]       opcode;
  logic             masked_flag;
  logic [LenW-1:0]  payload_length;
  logic [ByteW-1:0] payload_byte;
  logic             last;

  modport source (output valid, output kind, output fin_flag, output opcode,
                  output masked_flag, output payload_length, output payload_byte,
                  output last, input ready);
  modport sink   (input valid, input kind, input fin_flag, input opcode,
                  input masked_flag, input payload_length, input payload_byte,
                  input last, output ready);
endinterface
`default_nettype wire

@@ src/wsfp_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfp_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsfp_in_stage (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output      logic                    ready_o,
  input  wire logic [wsfp_pkg::ByteW-1:0] byte_i,
  output      logic                    valid_o,
  input  wire logic                    take_i,
  output      logic [wsfp_pkg::ByteW-1:0] byte_o
);
  import wsfp_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign ready_o = ~valid_q | take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end
endmodule
`default_nettype wire

@@ src/wsfp_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfp_core
// Frame state and per-byte decode: header fields, length, mask key, unmask.
// ----------------------------------------------------------------------------
module wsfp_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [wsfp_pkg::ByteW-1:0] in_byte_i,
  output      logic                       take_o,
  output      logic                       res_valid_o,
  output      wsfp_pkg::res_t             res_o,
  input  wire logic                       res_ready_i
);
  import wsfp_pkg::*;

  phase_e           phase_q, phase_d;
  logic             fin_q, fin_d;
  logic [3:0]       op_q, op_d;
  logic             masked_q, masked_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [2:0]       hbc_q, hbc_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [1:0]       kpos_q, kpos_d;
  logic [LenW-1:0]  left_q, left_d;

  logic             len_done, hdr, emit, last_flag, kind_bit;
  logic [ByteW-1:0] pbyte, key_byte;
  logic [6:0]       len7;
  logic [3:0]       cnt_inc, need;

  assign take_o = in_valid_i & res_ready_i;
  assign len7   = in_byte_i[6:0];

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    op_d      = op_q;
    masked_d  = masked_q;
    len_d     = len_q;
    hbc_d     = hbc_q;
    key_d     = key_q;
    kpos_d    = kpos_q;
    left_d    = left_q;
    len_done  = 1'b0;
    hdr       = 1'b0;
    emit      = 1'b0;
    last_flag = 1'b0;
    kind_bit  = KIND_HEADER;
    pbyte     = '0;
    cnt_inc   = {1'b0, hbc_q} + 4'd1;
    need      = (phase_q == PH_LEN16) ? Len16Bytes : Len64Bytes;
    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    case (phase_q)
      PH_SECOND: begin
        masked_d = |(in_byte_i & FinMask);
        hbc_d    = '0;
        len_d    = '0;
        key_d    = '0;
        kpos_d   = '0;
        if (len7 == Len16Code) begin
          phase_d = PH_LEN16;
        end else if (len7 == Len64Code) begin
          phase_d = PH_LEN64;
        end else begin
          len_d    = {{(LenW-7){1'b0}}, len7};
          len_done = 1'b1;
        end
      end
      PH_LEN16, PH_LEN64: begin
        len_d = {len_q[LenW-ByteW-1:0], in_byte_i};
        if (cnt_inc >= need) begin
          len_done = 1'b1;
        end else begin
          hbc_d = cnt_inc[2:0];
        end
      end
      PH_KEY: begin
        key_d = {key_q[KeyW-ByteW-1:0], in_byte_i};
        if (hbc_q >= KeyLastIdx) begin
          hbc_d = '0;
          hdr   = 1'b1;
        end else begin
          hbc_d = cnt_inc[2:0];
        end
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        kind_bit  = KIND_PAYLOAD;
        pbyte     = in_byte_i ^ key_byte;
        last_flag = (left_q <= 64'd1);
        kpos_d    = kpos_q + 2'd1;
        if (last_flag) begin
          left_d  = '0;
          phase_d = PH_FIRST;
        end else begin
          left_d = left_q - 64'd1;
        end
      end
      default: begin
        // first header byte; unused phase codes land here too
        fin_d   = |(in_byte_i & FinMask);
        op_d    = in_byte_i[3:0] & OpcodeMask[3:0];
        phase_d = PH_SECOND;
      end
    endcase

    if (len_done) begin
      hbc_d = '0;
      if (masked_d) begin
        phase_d = PH_KEY;
      end else begin
        hdr = 1'b1;
      end
    end

    if (hdr) begin
      emit      = 1'b1;
      last_flag = (len_d == '0);
      left_d    = len_d;
      kpos_d    = '0;
      phase_d   = last_flag ? PH_FIRST : PH_PAYLOAD;
    end
  end

  assign res_valid_o          = in_valid_i & emit;
  assign res_o.kind           = kind_bit;
  assign res_o.fin_flag       = fin_d;
  assign res_o.opcode         = op_d;
  assign res_o.masked_flag    = masked_d;
  assign res_o.payload_length = len_d;
  assign res_o.payload_byte   = pbyte;
  assign res_o.last           = last_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      fin_q    <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      hbc_q    <= '0;
      key_q    <= '0;
      kpos_q   <= '0;
      left_q   <= '0;
    end else if (take_o) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      hbc_q    <= hbc_d;
      key_q    <= key_d;
      kpos_q   <= kpos_d;
      left_q   <= left_d;
    end
  end
endmodule
`default_nettype wire

@@ src/wsfp_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsfp_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module wsfp_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire wsfp_pkg::res_t res_i,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      wsfp_pkg::res_t res_o
);
  import wsfp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end
endmodule
`default_nettype wire

@@ src/websocket_frame_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_parser
// RFC 6455 receive-side frame parser: header result, then unmasked payload.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   byte_i   in   in_byte (8)
//   res_o    out  kind, fin_flag, opcode, masked_flag, payload_length,
//                 payload_byte, last
//
// One byte is accepted per cycle while res_o does not stall; results are registered.
// The decode path is the 64-bit length shift and the 64-bit bytes-left
// decrement/compare between the input register and the result register.
// Reset clears all frame state; the parser then waits for a first header byte.
// A stall on res_o backs up through the result and input registers.
// ----------------------------------------------------------------------------
module websocket_frame_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsfp_byte_if.sink  byte_i,
  wsfp_res_if.source res_o
);
  import wsfp_pkg::*;

  logic             in_valid, take, core_valid, out_ready;
  logic [ByteW-1:0] in_byte;
  res_t             core_res, out_res;

  wsfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .byte_i  (byte_i.in_byte),
    .valid_o (in_valid),
    .take_i  (take),
    .byte_o  (in_byte)
  );

  wsfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_byte_i   (in_byte),
    .take_o      (take),
    .res_valid_o (core_valid),
    .res_o       (core_res),
    .res_ready_i (out_ready)
  );

  wsfp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .ready_o (out_ready),
    .res_i   (core_res),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (out_res)
  );

  assign res_o.kind           = out_res.kind;
  assign res_o.fin_flag       = out_res.fin_flag;
  assign res_o.opcode         = out_res.opcode;
  assign res_o.masked_flag    = out_res.masked_flag;
  assign res_o.payload_length = out_res.payload_length;
  assign res_o.payload_byte   = out_res.payload_byte;
  assign res_o.last           = out_res.last;
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds WebSocket frame bytes into websocket_frame_parser and checks every
// header and payload result against a cycle-free decoder kept here (typed
// script rows: the listed result). A short scripted part comes first, then
// random frames under varied flow control, an oversized frame closes the run.
// ----------------------------------------------------------------------------
module testbench;
  import wsfp_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdlePct [4] = '{0, 46, 0, 28};
  localparam int unsigned StallPct[4] = '{0, 0, 46, 28};
  localparam int unsigned FrameMax    = 320;
  localparam int unsigned PendDepth   = 64;

  typedef struct packed {
    logic [7:0] value;
    bit         typed;
    res_t       want;
  } step_t;

  localparam logic [63:0] HugeLen = 64'h8000_0000_0000_0000;

  // Rows before TailAt run first; the rest opens a frame that never ends and
  // so closes the run.
  localparam int TailAt = 21;
  localparam step_t Script[34] = '{
    // unmasked empty frame
    '{8'h89, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_HEADER, 1'b1, 4'h9, 1'b0, 64'd0, 8'h00, 1'b1}},
    // reserved bits set, masked empty frame
    '{8'h70, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b1, '{KIND_HEADER, 1'b0, 4'h0, 1'b1, 64'd0, 8'h00, 1'b1}},
    // masked two-byte payload
    '{8'hF2, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'h11, 1'b0, '0},
    '{8'h22, 1'b0, '0},
    '{8'h33, 1'b0, '0},
    '{8'h44, 1'b1, '{KIND_HEADER, 1'b1, 4'h2, 1'b1, 64'd2, 8'h00, 1'b0}},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    // non-minimal 16-bit length, unmasked
    '{8'h0F, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b1, '{KIND_HEADER, 1'b0, 4'hF, 1'b0, 64'd1, 8'h00, 1'b0}},
    '{8'hAB, 1'b1, '{KIND_PAYLOAD, 1'b0, 4'hF, 1'b0, 64'd1, 8'hAB, 1'b1}},
    // 64-bit length with the top bit set
    '{8'h8A, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_HEADER, 1'b1, 4'hA, 1'b0, HugeLen, 8'h00, 1'b0}},
    '{8'h5A, 1'b1, '{KIND_PAYLOAD, 1'b1, 4'hA, 1'b0, HugeLen, 8'h5A, 1'b0}},
    '{8'hC3, 1'b0, '0},
    '{8'h00, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  wsfp_byte_if byte_if ();
  wsfp_res_if  res_if ();

  websocket_frame_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .byte_i(byte_if),
    .res_o (res_if)
  );

  // Frame decoder state
  phase_e      prs_phase  = PH_FIRST;
  logic        prs_fin    = 1'b0;
  logic [3:0]  prs_opcode = 4'h0;
  logic        prs_masked = 1'b0;
  logic [63:0] prs_len    = '0;
  logic [2:0]  prs_cnt    = '0;
  logic [31:0] prs_key    = '0;
  logic [1:0]  prs_keypos = '0;
  logic [63:0] prs_left   = '0;

  res_t        pending_results [PendDepth];
  logic [5:0]  pend_wr    = '0;
  logic [5:0]  pend_rd    = '0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle  = 0;
  int unsigned res_stall  = 0;
  int unsigned hold_len   = 0;
  bit          hold_done  = 1'b0;
  bit          row_typed  = 1'b0;
  res_t        row_want   = '0;

  function automatic res_t make_result(input kind_e k, input logic [7:0] pb,
                                       input logic fin);
    res_t r;
    r.kind           = k;
    r.fin_flag       = prs_fin;
    r.opcode         = prs_opcode;
    r.masked_flag    = prs_masked;
    r.payload_length = prs_len;
    r.payload_byte   = pb;
    r.last           = fin;
    return r;
  endfunction

  function automatic bit close_header(output res_t r);
    r          = make_result(KIND_HEADER, 8'h00, prs_len == 64'd0);
    prs_left   = prs_len;
    prs_keypos = '0;
    if (prs_len == 64'd0) begin
      prs_phase = PH_FIRST;
    end else begin
      prs_phase = PH_PAYLOAD;
    end
    return 1'b1;
  endfunction

  function automatic bit length_complete(output res_t r);
    prs_cnt = '0;
    if (prs_masked) begin
      r         = '0;
      prs_phase = PH_KEY;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  // Advance the decoder by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    bit         hit;
    logic [3:0] need;
    logic [7:0] k;
    logic       fin;
    hit = 1'b0;
    r   = '0;
    case (prs_phase)
      PH_SECOND: begin
        prs_masked = b[7];
        prs_cnt    = '0;
        prs_len    = '0;
        prs_key    = '0;
        prs_keypos = '0;
        if (b[6:0] == Len16Code) begin
          prs_phase = PH_LEN16;
        end else if (b[6:0] == Len64Code) begin
          prs_phase = PH_LEN64;
        end else begin
          prs_len = {57'd0, b[6:0]};
          hit     = length_complete(r);
        end
      end
      PH_LEN16, PH_LEN64: begin
        need    = (prs_phase == PH_LEN16) ? Len16Bytes : Len64Bytes;
        prs_len = {prs_len[55:0], b};
        if (({1'b0, prs_cnt} + 4'd1) >= need) begin
          hit = length_complete(r);
        end else begin
          prs_cnt = prs_cnt + 3'd1;
        end
      end
      PH_KEY: begin
        prs_key = {prs_key[23:0], b};
        if (prs_cnt >= KeyLastIdx) begin
          prs_cnt = '0;
          hit     = close_header(r);
        end else begin
          prs_cnt = prs_cnt + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        k          = prs_key[8*(3-prs_keypos) +: 8];
        fin        = (prs_left <= 64'd1);
        r          = make_result(KIND_PAYLOAD, b ^ k, fin);
        hit        = 1'b1;
        prs_keypos = prs_keypos + 2'd1;
        if (fin) begin
          prs_left  = '0;
          prs_phase = PH_FIRST;
        end else begin
          prs_left = prs_left - 64'd1;
        end
      end
      default: begin
        prs_fin    = b[7];
        prs_opcode = b[3:0];
        prs_phase  = PH_SECOND;
      end
    endcase
    return hit;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one byte, idling first at random, and hold it until taken.
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    row_typed       = typed;
    row_want        = want;
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_random_frame();
    logic [7:0]  fb [FrameMax];
    int unsigned fb_len;
    int unsigned plen;
    int unsigned sel;
    logic        mask;
    logic [63:0] len64;
    fb_len = 0;
    sel    = $urandom_range(0, 99);
    mask   = 1'($urandom_range(0, 1));
    fb[fb_len] = 8'($urandom_range(0, 255));
    fb_len++;
    if (sel < 60) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      fb[fb_len] = {mask, 7'(plen)};
      fb_len++;
    end else if (sel < 85) begin
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      fb[fb_len] = {mask, Len16Code};
      fb_len++;
      fb[fb_len] = 8'(plen >> 8);
      fb_len++;
      fb[fb_len] = 8'(plen);
      fb_len++;
    end else begin
      plen  = $urandom_range(0, 24);
      len64 = 64'(plen);
      fb[fb_len] = {mask, Len64Code};
      fb_len++;
      for (int i = 7; i >= 0; i--) begin
        fb[fb_len] = len64[8*i +: 8];
        fb_len++;
      end
    end
    if (mask) begin
      repeat (4) begin
        fb[fb_len] = 8'($urandom_range(0, 255));
        fb_len++;
      end
    end
    repeat (plen) begin
      fb[fb_len] = 8'($urandom_range(0, 255));
      fb_len++;
    end
    for (int unsigned i = 0; i < fb_len; i++) send_byte(fb[i], 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predict on every accepted byte, then check every accepted result.
  always @(posedge clk) begin : scoreboard
    bit   hit;
    res_t r;
    res_t want;
    if (rst_n) begin
      if (byte_if.valid && byte_if.ready) begin
        hit = parse_byte(byte_if.in_byte, r);
        if (row_typed) begin
          if (!hit) flag_mismatch("listed result not produced by decoder", 64'd0, 64'd1);
          pending_results[pend_wr] = row_want;
          pend_wr = pend_wr + 6'd1;
        end else if (hit) begin
          pending_results[pend_wr] = r;
          pend_wr = pend_wr + 6'd1;
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (pend_wr == pend_rd) begin
          flag_mismatch("result with none expected, length", res_if.payload_length, 64'd0);
        end else begin
          want    = pending_results[pend_rd];
          pend_rd = pend_rd + 6'd1;
          if (res_if.kind !== want.kind)
            flag_mismatch("kind", 64'(res_if.kind), 64'(want.kind));
          if (res_if.fin_flag !== want.fin_flag)
            flag_mismatch("fin_flag", 64'(res_if.fin_flag), 64'(want.fin_flag));
          if (res_if.opcode !== want.opcode)
            flag_mismatch("opcode", 64'(res_if.opcode), 64'(want.opcode));
          if (res_if.masked_flag !== want.masked_flag)
            flag_mismatch("masked_flag", 64'(res_if.masked_flag), 64'(want.masked_flag));
          if (res_if.payload_length !== want.payload_length)
            flag_mismatch("payload_length", res_if.payload_length, want.payload_length);
          if (res_if.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", 64'(res_if.payload_byte), 64'(want.payload_byte));
          if (res_if.last !== want.last)
            flag_mismatch("last", 64'(res_if.last), 64'(want.last));
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0 && !hold_done) begin
        hold_done = 1'b1;
        repeat (hold_len) begin
          res_if.ready <= 1'b0;
          @(negedge clk);
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= res_stall);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start;
    rst_n           = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < TailAt; i++) begin
      send_byte(Script[i].value, Script[i].typed, Script[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle = IdlePct[p];
      res_stall = StallPct[p];
      // keep offering while results back up, so the input stalls
      if (p == 0) hold_len = HoldCycles;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RandomItems / 4) send_random_frame();
    end

    for (int i = TailAt; i < $size(Script); i++) begin
      send_byte(Script[i].value, Script[i].typed, Script[i].want);
    end
    @(negedge clk);
    byte_if.valid <= 1'b0;

    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/wsfp_pkg.sv
src/wsfp_if.sv
src/wsfp_in_stage.sv
src/wsfp_core.sv
src/wsfp_out_stage.sv
src/websocket_frame_parser.sv
dv/testbench.sv
